// ===== sv/okvt_pkg.sv =====
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types and constants for the ordered key/value table: request codes,
// default sizes, and the control structs for the chain of entry cells.
// ----------------------------------------------------------------------------
package okvt_pkg;

    // default sizes
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // request codes
    typedef enum logic [2:0] {
        FUNC_INSERT     = 3'd0,
        FUNC_UPDATE     = 3'd1,
        FUNC_INS_OR_UPD = 3'd2,
        FUNC_ERASE      = 3'd3,
        FUNC_CONTAINS   = 3'd4,
        FUNC_GET_KEY    = 3'd5,
        FUNC_GET_INDEX  = 3'd6,
        FUNC_CLEAR      = 3'd7
    } func_t;

    // search wave moving from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } wave_ctl_t;

    // commit command broadcast to all cells
    typedef struct packed {
        logic write_match;
        logic append;
        logic erase;
    } cell_cmd_t;

endpackage

// ===== sv/okvt_cell.sv =====
// ----------------------------------------------------------------------------
// okvt_cell
// One entry of the table. Holds a key/value pair, checks it against the
// search wave as the wave passes, and forwards the first hit downstream.
// On commit it takes the pair of its upper neighbor (erase), the new pair
// (append at the current count) or a new value (update of the matched entry).
// ----------------------------------------------------------------------------
module okvt_cell #(
    parameter int INDEX       = 0,
    parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH,
    parameter int CNT_WIDTH   = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // search wave in
    input  okvt_pkg::wave_ctl_t        wave_in,
    input  logic [KEY_WIDTH-1:0]       wave_key_in,
    input  logic [VALUE_WIDTH-1:0]     wave_value_in,
    // search wave out
    output okvt_pkg::wave_ctl_t        wave_out,
    output logic [KEY_WIDTH-1:0]       wave_key_out,
    output logic [VALUE_WIDTH-1:0]     wave_value_out,
    // request broadcast
    input  logic                       by_index,
    input  logic [KEY_WIDTH-1:0]       req_key,
    input  logic [VALUE_WIDTH-1:0]     req_value,
    input  logic [CNT_WIDTH-1:0]       req_pos,
    input  logic [CNT_WIDTH-1:0]       count,
    input  okvt_pkg::cell_cmd_t        cmd,
    // neighbor pair for erase
    input  logic [KEY_WIDTH-1:0]       nbr_key,
    input  logic [VALUE_WIDTH-1:0]     nbr_value,
    output logic [KEY_WIDTH-1:0]       entry_key,
    output logic [VALUE_WIDTH-1:0]     entry_value
);
    import okvt_pkg::*;

    localparam logic [CNT_WIDTH-1:0] MY_POS = CNT_WIDTH'(INDEX);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   match_reg;
    logic                   prefix_reg;
    wave_ctl_t              wave_reg;
    logic [KEY_WIDTH-1:0]   wave_key_reg;
    logic [VALUE_WIDTH-1:0] wave_value_reg;
    logic                   occupied;
    logic                   local_hit;

    // entry is live below the count
    assign occupied  = (MY_POS < count);
    assign local_hit = occupied && (by_index ? (req_pos == MY_POS) : (req_key == key_reg));

    // wave control and per-entry search flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg   <= '0;
            match_reg  <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else
        begin
            wave_reg.valid <= wave_in.valid;
            wave_reg.hit   <= wave_in.hit || local_hit;
            if (wave_in.valid)
            begin
                match_reg  <= local_hit;
                prefix_reg <= wave_in.hit || local_hit;
            end
        end
    end

    // wave payload: first hit wins
    always_ff @(posedge clk)
    begin
        if (wave_in.valid)
        begin
            if (wave_in.hit)
            begin
                wave_key_reg   <= wave_key_in;
                wave_value_reg <= wave_value_in;
            end
            else
            begin
                wave_key_reg   <= key_reg;
                wave_value_reg <= value_reg;
            end
        end
    end

    // stored pair update on commit
    always_ff @(posedge clk)
    begin
        if (cmd.erase && prefix_reg)
        begin
            key_reg   <= nbr_key;
            value_reg <= nbr_value;
        end
        else if (cmd.append && (count == MY_POS))
        begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
        else if (cmd.write_match && match_reg)
        begin
            value_reg <= req_value;
        end
    end

    assign wave_out       = wave_reg;
    assign wave_key_out   = wave_key_reg;
    assign wave_value_out = wave_value_reg;
    assign entry_key      = key_reg;
    assign entry_value    = value_reg;

endmodule

// ===== sv/ordered_key_value_table.sv =====
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Bounded table of unique key/value pairs kept in insertion order, built as
// a chain of entry cells that a search wave walks through.
//
//   channel   ports                                  handshake
//   request   func key_in value_in index_in          start, taken when busy low
//   result    ok key_out value_out count_out         done, one-cycle strobe
//
// A request is launched (launch_reg), its wave crosses the cell chain, and
// it commits as the wave leaves the last cell; done_reg then raises the
// done strobe. busy is low in the cycle of the done strobe, so a new request
// can be taken then. Reset empties the table (count zero); stored pairs are
// not cleared. The receiver cannot stall: done is high for one cycle only.
// ----------------------------------------------------------------------------
module ordered_key_value_table #(
    parameter int TABLE_DEPTH = okvt_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH,
    parameter int IDX_WIDTH   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              func,
    input  logic [KEY_WIDTH-1:0]    key_in,
    input  logic [VALUE_WIDTH-1:0]  value_in,
    input  logic [IDX_WIDTH-1:0]    index_in,
    output logic                    done,
    output logic                    ok,
    output logic [KEY_WIDTH-1:0]    key_out,
    output logic [VALUE_WIDTH-1:0]  value_out,
    output logic [CNT_WIDTH-1:0]    count_out
);
    import okvt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    logic [CNT_WIDTH-1:0]   count_reg, count_next;
    logic                   launch_reg;
    logic                   done_reg;
    func_t                  req_func_reg;
    logic [KEY_WIDTH-1:0]   req_key_reg;
    logic [VALUE_WIDTH-1:0] req_value_reg;
    logic [IDX_WIDTH-1:0]   req_index_reg;
    logic                   ok_reg, ok_next;
    logic [KEY_WIDTH-1:0]   key_out_reg, key_out_next;
    logic [VALUE_WIDTH-1:0] value_out_reg, value_out_next;

    logic                   accept;
    logic                   commit;
    logic                   full;
    logic                   by_index;
    cell_cmd_t              cmd;

    wave_ctl_t              wave     [TABLE_DEPTH+1];
    logic [KEY_WIDTH-1:0]   wave_key [TABLE_DEPTH+1];
    logic [VALUE_WIDTH-1:0] wave_val [TABLE_DEPTH+1];
    logic [KEY_WIDTH-1:0]   cell_key [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] cell_val [TABLE_DEPTH];

    assign accept   = start && (state_reg == ST_IDLE);
    assign commit   = (state_reg == ST_SCAN) && wave[TABLE_DEPTH].valid;
    assign full     = (count_reg == FULL_COUNT);
    assign by_index = (req_func_reg == FUNC_GET_INDEX);

    // wave enters the chain with no hit
    assign wave[0].valid = launch_reg;
    assign wave[0].hit   = 1'b0;
    assign wave_key[0]   = '0;
    assign wave_val[0]   = '0;

    // chain of entry cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]   nbr_key;
        logic [VALUE_WIDTH-1:0] nbr_value;

        if (i < TABLE_DEPTH - 1)
        begin : g_mid
            assign nbr_key   = cell_key[i+1];
            assign nbr_value = cell_val[i+1];
        end
        else
        begin : g_last
            assign nbr_key   = cell_key[i];
            assign nbr_value = cell_val[i];
        end

        okvt_cell #(
            .INDEX       (i),
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_WIDTH   (CNT_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .wave_in        (wave[i]),
            .wave_key_in    (wave_key[i]),
            .wave_value_in  (wave_val[i]),
            .wave_out       (wave[i+1]),
            .wave_key_out   (wave_key[i+1]),
            .wave_value_out (wave_val[i+1]),
            .by_index       (by_index),
            .req_key        (req_key_reg),
            .req_value      (req_value_reg),
            .req_pos        (CNT_WIDTH'(req_index_reg)),
            .count          (count_reg),
            .cmd            (cmd),
            .nbr_key        (nbr_key),
            .nbr_value      (nbr_value),
            .entry_key      (cell_key[i]),
            .entry_value    (cell_val[i])
        );
    end

    // commit decision once the wave leaves the last cell
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd            = '0;
        ok_next        = 1'b0;
        key_out_next   = '0;
        value_out_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                    case (req_func_reg)
                        FUNC_INSERT:
                        begin
                            if (!wave[TABLE_DEPTH].hit && !full)
                            begin
                                cmd.append = 1'b1;
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        FUNC_UPDATE:
                        begin
                            if (wave[TABLE_DEPTH].hit)
                            begin
                                cmd.write_match = 1'b1;
                                ok_next         = 1'b1;
                            end
                        end
                        FUNC_INS_OR_UPD:
                        begin
                            if (wave[TABLE_DEPTH].hit)
                            begin
                                cmd.write_match = 1'b1;
                                ok_next         = 1'b1;
                            end
                            else if (!full)
                            begin
                                cmd.append = 1'b1;
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        FUNC_ERASE:
                        begin
                            if (wave[TABLE_DEPTH].hit)
                            begin
                                cmd.erase  = 1'b1;
                                count_next = count_reg - 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        FUNC_CONTAINS:
                        begin
                            ok_next = wave[TABLE_DEPTH].hit;
                        end
                        FUNC_GET_KEY:
                        begin
                            if (wave[TABLE_DEPTH].hit)
                            begin
                                ok_next        = 1'b1;
                                value_out_next = wave_val[TABLE_DEPTH];
                            end
                        end
                        FUNC_GET_INDEX:
                        begin
                            if (wave[TABLE_DEPTH].hit)
                            begin
                                ok_next        = 1'b1;
                                key_out_next   = wave_key[TABLE_DEPTH];
                                value_out_next = wave_val[TABLE_DEPTH];
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            launch_reg <= accept;
            done_reg   <= commit;
        end
    end

    // request capture on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_func_reg  <= func_t'(func);
            req_key_reg   <= key_in;
            req_value_reg <= value_in;
            req_index_reg <= index_in;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            ok_reg        <= ok_next;
            key_out_reg   <= key_out_next;
            value_out_reg <= value_out_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign key_out   = key_out_reg;
    assign value_out = value_out_reg;
    assign count_out = count_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered key/value table. A scoreboard class
// keeps its own copy of the table, works out the result of every request
// transfer, and checks each done strobe against the oldest outstanding
// result. Directed requests hit the empty, duplicate, shift-on-erase and
// clear cases. Random traffic then follows, mostly on a small key pool so
// that hits, misses and a full table all happen often.
// ----------------------------------------------------------------------------
module tb_top;
    import okvt_pkg::*;

    localparam int DEPTH     = DEF_TABLE_DEPTH;
    localparam int KW        = DEF_KEY_WIDTH;
    localparam int VW        = DEF_VALUE_WIDTH;
    localparam int IW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int LATENCY   = DEPTH + 2;
    localparam int MAX_CYCLES = 400000;
    localparam int POOL_SIZE = 24;
    localparam int PHASE_ITEMS = 600;

    // one result of the table
    typedef struct packed {
        logic          ok;
        logic [KW-1:0] key;
        logic [VW-1:0] value;
        logic [CW-1:0] count;
    } table_result_t;

    // shadow table plus the results still owed by the block
    class table_scoreboard;
        logic [KW-1:0] keys [DEPTH];
        logic [VW-1:0] values [DEPTH];
        int unsigned   fill;
        int unsigned   errors;
        table_result_t expected_results [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // position of the key, or fill when absent
        function int unsigned locate(logic [KW-1:0] k);
            for (int unsigned i = 0; i < fill; i++)
                if (keys[i] == k)
                    return i;
            return fill;
        endfunction

        function bit store_at_end(logic [KW-1:0] k, logic [VW-1:0] v);
            if (fill >= DEPTH)
                return 1'b0;
            keys[fill]   = k;
            values[fill] = v;
            fill++;
            return 1'b1;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        // apply one accepted request to the shadow table
        function void predict_request(func_t f, logic [KW-1:0] k, logic [VW-1:0] v,
                                      logic [IW-1:0] idx);
            table_result_t r;
            int unsigned   pos;
            bit            hit;
            r   = '0;
            pos = locate(k);
            hit = pos < fill;
            case (f)
                FUNC_INSERT:
                    if (!hit)
                        r.ok = store_at_end(k, v);
                FUNC_UPDATE:
                    if (hit)
                    begin
                        values[pos] = v;
                        r.ok = 1'b1;
                    end
                FUNC_INS_OR_UPD:
                    if (hit)
                    begin
                        values[pos] = v;
                        r.ok = 1'b1;
                    end
                    else
                        r.ok = store_at_end(k, v);
                FUNC_ERASE:
                    if (hit)
                    begin
                        // close the gap, keep insertion order
                        for (int unsigned i = pos; i + 1 < fill; i++)
                        begin
                            keys[i]   = keys[i + 1];
                            values[i] = values[i + 1];
                        end
                        fill--;
                        r.ok = 1'b1;
                    end
                FUNC_CONTAINS:
                    r.ok = hit;
                FUNC_GET_KEY:
                    if (hit)
                    begin
                        r.value = values[pos];
                        r.ok    = 1'b1;
                    end
                FUNC_GET_INDEX:
                    if (idx < fill)
                    begin
                        r.key   = keys[idx];
                        r.value = values[idx];
                        r.ok    = 1'b1;
                    end
                default:
                begin
                    fill = 0;
                    r.ok = 1'b1;
                end
            endcase
            r.count = CW'(fill);
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("tb_top: mismatch: %s", msg);
            errors++;
        endtask

        // compare one done strobe with the oldest owed result
        task check_result(table_result_t got);
            table_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok)
                report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
            if (got.key !== want.key)
                report_mismatch($sformatf("key_out %h, want %h", got.key, want.key));
            if (got.value !== want.value)
                report_mismatch($sformatf("value_out %h, want %h", got.value, want.value));
            if (got.count !== want.count)
                report_mismatch($sformatf("count_out %0d, want %0d", got.count, want.count));
        endtask

        task check_leftover();
            if (expected_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_results.size()));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    func_t         func;
    logic [KW-1:0] key_in;
    logic [VW-1:0] value_in;
    logic [IW-1:0] index_in;
    logic          done;
    logic          ok;
    logic [KW-1:0] key_out;
    logic [VW-1:0] value_out;
    logic [CW-1:0] count_out;

    table_scoreboard sb;
    logic [KW-1:0]   key_pool [POOL_SIZE];
    int unsigned     cycle_count;

    ordered_key_value_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .key_in    (key_in),
        .value_in  (value_in),
        .index_in  (index_in),
        .done      (done),
        .ok        (ok),
        .key_out   (key_out),
        .value_out (value_out),
        .count_out (count_out)
    );

    // clock, period 12
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{ok: ok, key: key_out, value: value_out, count: count_out});
    end

    // one request transfer; called and returns at a falling edge
    task automatic send(func_t f, logic [KW-1:0] k, logic [VW-1:0] v, logic [IW-1:0] idx);
        func     = f;
        key_in   = k;
        value_in = v;
        index_in = idx;
        start    = 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.predict_request(f, k, v, idx);
        @(negedge clk);
    endtask

    // wait until the block is ready, then idle cycle by cycle at the given rate
    task automatic idle_cycles(int unsigned pct);
        start = 1'b0;
        while (busy)
            @(negedge clk);
        while ($urandom_range(0, 99) < pct)
            @(negedge clk);
    endtask

    // hold off until every owed result is back
    task automatic drain();
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // mostly keys that are stored or in the pool, so lookups hit
    function automatic logic [KW-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40 && sb.fill > 0)
            return sb.keys[$urandom_range(0, sb.fill - 1)];
        if (r < 88)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [VW-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 6)
            return '1;
        return $urandom;
    endfunction

    function automatic func_t pick_func();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return FUNC_INSERT;
        if (r < 40)
            return FUNC_UPDATE;
        if (r < 55)
            return FUNC_INS_OR_UPD;
        if (r < 70)
            return FUNC_ERASE;
        if (r < 78)
            return FUNC_CONTAINS;
        if (r < 86)
            return FUNC_GET_KEY;
        if (r < 97)
            return FUNC_GET_INDEX;
        return FUNC_CLEAR;
    endfunction

    // stimulus
    initial
    begin
        int unsigned idle_pct;
        sb          = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_CONTAINS;
        key_in      = '0;
        value_in    = '0;
        index_in    = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table: every lookup misses
        send(FUNC_GET_INDEX, '0, '0, '0);
        send(FUNC_ERASE, 32'h1234_5678, '0, '0);
        send(FUNC_UPDATE, 32'h1234_5678, 32'h1111_1111, '0);
        send(FUNC_GET_KEY, '0, '0, '0);
        // extremes in, then duplicate insert fails
        send(FUNC_INSERT, '0, '1, '1);
        send(FUNC_INSERT, '1, '0, '0);
        send(FUNC_INSERT, '0, 32'h0000_0001, '0);
        send(FUNC_INS_OR_UPD, '0, 32'h0000_0002, '0);
        send(FUNC_INS_OR_UPD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0);
        send(FUNC_UPDATE, '1, 32'hDEAD_BEEF, '0);
        send(FUNC_GET_KEY, '1, '0, '0);
        send(FUNC_GET_INDEX, '0, '0, IW'(2));
        send(FUNC_GET_INDEX, '0, '0, '1);
        // erase the head, later pairs shift down
        send(FUNC_ERASE, '0, '0, '0);
        send(FUNC_GET_INDEX, '0, '0, '0);
        send(FUNC_CONTAINS, '0, '0, '0);
        send(FUNC_CONTAINS, 32'hA5A5_A5A5, '0, '0);
        // clear, then stale positions must not read back
        send(FUNC_CLEAR, '0, '0, '0);
        send(FUNC_GET_INDEX, '0, '0, '0);
        send(FUNC_CLEAR, '1, '1, '1);
        drain();

        // random traffic: sender idles rarely, often, then never
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 80 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (idle_pct != 0)
                    idle_cycles(idle_pct);
                send(pick_func(), pick_key(), pick_value(), IW'($urandom_range(0, DEPTH - 1)));
            end
            drain();
        end

        repeat (2 * LATENCY) @(negedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
